// File: rtl/frwl_pkg.sv
// ----------------------------------------------------------------------------
// frwl_pkg
// Types and constants shared by the FIFO readers-writers lock manager.
// ----------------------------------------------------------------------------
`default_nettype none

package frwl_pkg;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] EV_GRANT       = 2'd0;
  localparam logic [1:0] EV_QUEUE_FULL  = 2'd1;
  localparam logic [1:0] EV_BAD_RELEASE = 2'd2;

  localparam int unsigned ReaderBits = 9;
  localparam logic [ReaderBits-1:0] ReaderMax = 9'd511;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  typedef struct packed {
    logic       op;
    logic [7:0] requester_id;
    logic       is_write;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] granted_id;
    logic       granted_write;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic grant;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic grantable;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/fifo_readers_writers_lock.sv
// ----------------------------------------------------------------------------
// fifo_readers_writers_lock
// Strict-FIFO readers-writers lock manager for one resource.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------
//   in      | input     | in_valid_i/in_ready_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_item_o (out_item_t)
//
// A transaction is taken in ST_IDLE; each grant is then one registered read
// of the queue memory at the head (ST_READ) followed by its evaluation (ST_EVAL).
// Reset clears pointers, counts and lock state; the queue memory is not
// cleared. A stalled output holds the sequencer; in_ready_o is high only
// while no transaction is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_readers_writers_lock #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  frwl_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output frwl_pkg::out_item_t  out_item_o
);

  frwl_pkg::cmd_t    cmd;
  frwl_pkg::status_t sts;

  frwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frwl_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.grant |-> sts.grantable)
    else $error("grant issued while head not grantable");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.grant && cmd.flush) && !(cmd.accept && (cmd.grant || cmd.flush)))
    else $error("conflicting datapath commands");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |=> out_valid_o && out_item_o.last_of_run)
    else $error("final result of run not marked last");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken while one is in progress");

endmodule

`default_nettype wire

// File: rtl/frwl_ctrl.sv
// ----------------------------------------------------------------------------
// frwl_ctrl
// Sequencer: takes one transaction, then reads and evaluates the queue head
// once per grant until the head is no longer grantable.
// ----------------------------------------------------------------------------
`default_nettype none

module frwl_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  frwl_pkg::status_t  sts_i,
  output frwl_pkg::cmd_t     cmd_o
);

  frwl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frwl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      frwl_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = frwl_pkg::ST_READ;
      end
      frwl_pkg::ST_READ: begin
        state_d = frwl_pkg::ST_EVAL;
      end
      frwl_pkg::ST_EVAL: begin
        if (sts_i.grantable) begin
          if (!sts_i.pend_valid || sts_i.out_free) state_d = frwl_pkg::ST_READ;
        end else if (!sts_i.pend_valid || sts_i.out_free) begin
          state_d = frwl_pkg::ST_IDLE;
        end
      end
      default: state_d = frwl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      frwl_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      frwl_pkg::ST_EVAL: begin
        if (sts_i.grantable) begin
          cmd_o.grant = !sts_i.pend_valid || sts_i.out_free;
        end else begin
          cmd_o.flush = sts_i.pend_valid && sts_i.out_free;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/frwl_dpath.sv
// ----------------------------------------------------------------------------
// frwl_dpath
// Request queue memory, lock state, one pending result and the output
// register. The pending result is held back until it is known whether it
// ends the run.
// ----------------------------------------------------------------------------
`default_nettype none

module frwl_dpath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  frwl_pkg::in_item_t   in_item_i,
  input  frwl_pkg::cmd_t       cmd_i,
  output frwl_pkg::status_t    sts_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output frwl_pkg::out_item_t  out_item_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [ID_BITS:0] mem_q [QUEUE_DEPTH];
  logic [ID_BITS:0] rd_q;

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [frwl_pkg::ReaderBits-1:0] readers_q, readers_d;
  logic excl_q, excl_d;
  logic [frwl_pkg::ResCntW-1:0] nres_q, nres_d;
  logic pend_v_q, pend_v_d;
  frwl_pkg::out_item_t pend_q, pend_d;
  logic out_v_q, out_v_d;
  frwl_pkg::out_item_t out_q, out_d;

  logic [ID_BITS-1:0] in_id;
  logic               q_full, q_write, rd_write;

  assign in_id    = ID_BITS'(in_item_i.requester_id);
  assign q_full   = (count_q == CntW'(QUEUE_DEPTH));
  assign q_write  = cmd_i.accept && (in_item_i.op == frwl_pkg::OP_ACQUIRE) && !q_full;
  assign rd_write = rd_q[ID_BITS];

  always_ff @(posedge clk_i) begin
    if (q_write) mem_q[tail_q] <= {in_item_i.is_write, in_id};
    rd_q <= mem_q[head_q];
  end

  always_comb begin
    sts_o.pend_valid = pend_v_q;
    sts_o.out_free   = !out_v_q || out_ready_i;
    sts_o.grantable  = (count_q != '0) && !excl_q &&
                       (nres_q < frwl_pkg::ResCntW'(frwl_pkg::MaxResults)) &&
                       (rd_write ? (readers_q == '0) : (readers_q != frwl_pkg::ReaderMax));
  end

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    readers_d = readers_q;
    excl_d    = excl_q;
    nres_d    = nres_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    out_v_d   = out_v_q && !out_ready_i;
    out_d     = out_q;

    if (cmd_i.accept) begin
      pend_v_d              = 1'b0;
      nres_d                = '0;
      pend_d.granted_id     = 8'(in_id);
      pend_d.granted_write  = in_item_i.is_write;
      pend_d.last_of_run    = 1'b0;
      pend_d.event_kind     = frwl_pkg::EV_BAD_RELEASE;
      if (in_item_i.op == frwl_pkg::OP_ACQUIRE) begin
        if (q_full) begin
          pend_d.event_kind = frwl_pkg::EV_QUEUE_FULL;
          pend_v_d          = 1'b1;
          nres_d            = frwl_pkg::ResCntW'(1);
        end else begin
          tail_d  = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          count_d = count_q + 1'b1;
        end
      end else if (in_item_i.is_write) begin
        if (excl_q) begin
          excl_d = 1'b0;
        end else begin
          pend_v_d = 1'b1;
          nres_d   = frwl_pkg::ResCntW'(1);
        end
      end else begin
        if (readers_q != '0) begin
          readers_d = readers_q - 1'b1;
        end else begin
          pend_v_d = 1'b1;
          nres_d   = frwl_pkg::ResCntW'(1);
        end
      end
    end

    if (cmd_i.grant) begin
      if (pend_v_q) begin
        out_v_d             = 1'b1;
        out_d               = pend_q;
        out_d.last_of_run   = 1'b0;
      end
      if (rd_write) excl_d = 1'b1;
      else readers_d = readers_q + 1'b1;
      head_d               = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d              = count_q - 1'b1;
      nres_d               = nres_q + 1'b1;
      pend_v_d             = 1'b1;
      pend_d.event_kind    = frwl_pkg::EV_GRANT;
      pend_d.granted_id    = 8'(rd_q[ID_BITS-1:0]);
      pend_d.granted_write = rd_write;
      pend_d.last_of_run   = 1'b0;
    end

    if (cmd_i.flush) begin
      out_v_d           = 1'b1;
      out_d             = pend_q;
      out_d.last_of_run = 1'b1;
      pend_v_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      readers_q <= '0;
      excl_q    <= 1'b0;
      nres_q    <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      readers_q <= readers_d;
      excl_q    <= excl_d;
      nres_q    <= nres_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: dv/tb_fifo_readers_writers_lock.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_readers_writers_lock
// Self-checking bench for the FIFO readers-writers lock manager. A directed
// table covers the corner cases: unmatched releases, a full queue, a sixteen
// grant burst and strict FIFO order. A random phase follows. Each output
// transaction is checked against a fixed table result or a local lock model,
// with random idle cycles on both channels outside one random stretch.
// ----------------------------------------------------------------------------
module tb_fifo_readers_writers_lock;

  localparam int unsigned Depth      = 16;
  localparam int unsigned NumRandom  = 375;
  localparam int unsigned TailCycles = 3 + 2 * frwl_pkg::MaxResults + 5;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned NumRows    = 25;

  typedef struct packed {
    frwl_pkg::in_item_t  item;
    logic                fixed;
    frwl_pkg::out_item_t fixed_res;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  frwl_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready = 1'b0;
  frwl_pkg::out_item_t out_item;

  // lock model state
  logic [7:0]                      pend_id [Depth];
  logic                            pend_wr [Depth];
  logic [3:0]                      pend_head;
  logic [3:0]                      pend_tail;
  logic [4:0]                      pend_cnt;
  logic [frwl_pkg::ReaderBits-1:0] readers_held;
  logic                            writer_held;

  frwl_pkg::out_item_t step_events[$];
  frwl_pkg::out_item_t expected_events[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic        in_idle_en = 1'b1;
  logic        out_idle_en = 1'b1;

  // item: {op, id, is_write}  fixed flag  result: {kind, id, write, last}
  dir_row_t directed [NumRows] = '{
    {frwl_pkg::OP_RELEASE, 8'hFF, 1'b1, 1'b1, frwl_pkg::EV_BAD_RELEASE, 8'hFF, 1'b1, 1'b1},
    {frwl_pkg::OP_RELEASE, 8'h00, 1'b0, 1'b1, frwl_pkg::EV_BAD_RELEASE, 8'h00, 1'b0, 1'b1},
    {frwl_pkg::OP_ACQUIRE, 8'h80, 1'b1, 1'b1, frwl_pkg::EV_GRANT,       8'h80, 1'b1, 1'b1},
    {frwl_pkg::OP_ACQUIRE, 8'h00, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'hFF, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h01, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h02, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h03, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h04, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h05, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h06, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h07, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h08, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h09, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h0A, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h0B, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h0C, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h0D, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h0E, 1'b0, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h7F, 1'b1, 1'b1, frwl_pkg::EV_QUEUE_FULL,  8'h7F, 1'b1, 1'b1},
    {frwl_pkg::OP_RELEASE, 8'h33, 1'b0, 1'b1, frwl_pkg::EV_BAD_RELEASE, 8'h33, 1'b0, 1'b1},
    {frwl_pkg::OP_RELEASE, 8'h80, 1'b1, 1'b0, 12'h000},
    {frwl_pkg::OP_ACQUIRE, 8'h2A, 1'b1, 1'b0, 12'h000},
    {frwl_pkg::OP_RELEASE, 8'hC3, 1'b1, 1'b1, frwl_pkg::EV_BAD_RELEASE, 8'hC3, 1'b1, 1'b1},
    {frwl_pkg::OP_ACQUIRE, 8'h5A, 1'b0, 1'b0, 12'h000}
  };

  fifo_readers_writers_lock uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic frwl_pkg::out_item_t lock_event(input logic [1:0] kind,
                                                     input logic [7:0] id,
                                                     input logic wr);
    lock_event = {kind, id, wr, 1'b0};
  endfunction

  task automatic lock_step(input frwl_pkg::in_item_t it);
    step_events.delete();
    if (it.op == frwl_pkg::OP_ACQUIRE) begin
      if (pend_cnt >= Depth) begin
        step_events = {step_events,
                       lock_event(frwl_pkg::EV_QUEUE_FULL, it.requester_id, it.is_write)};
      end else begin
        pend_id[pend_tail] = it.requester_id;
        pend_wr[pend_tail] = it.is_write;
        pend_tail = pend_tail + 1'b1;
        pend_cnt = pend_cnt + 1'b1;
      end
    end else if (it.is_write) begin
      if (writer_held) writer_held = 1'b0;
      else step_events = {step_events,
                          lock_event(frwl_pkg::EV_BAD_RELEASE, it.requester_id, 1'b1)};
    end else begin
      if (readers_held != 0) readers_held = readers_held - 1'b1;
      else step_events = {step_events,
                          lock_event(frwl_pkg::EV_BAD_RELEASE, it.requester_id, 1'b0)};
    end
    while (step_events.size() < frwl_pkg::MaxResults && pend_cnt != 0 && !writer_held &&
           (pend_wr[pend_head] ? readers_held == 0
                               : readers_held != frwl_pkg::ReaderMax)) begin
      if (pend_wr[pend_head]) writer_held = 1'b1;
      else readers_held = readers_held + 1'b1;
      step_events = {step_events,
                     lock_event(frwl_pkg::EV_GRANT, pend_id[pend_head], pend_wr[pend_head])};
      pend_head = pend_head + 1'b1;
      pend_cnt = pend_cnt - 1'b1;
    end
    if (step_events.size() != 0) begin
      step_events[step_events.size() - 1].last_of_run = 1'b1;
    end
  endtask

  // called and returns at a falling edge
  task automatic drive_item(input frwl_pkg::in_item_t it, input logic fixed,
                            input frwl_pkg::out_item_t fixed_res);
    while (in_idle_en && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    lock_step(it);
    if (fixed) expected_events = {expected_events, fixed_res};
    else expected_events = {expected_events, step_events};
    @(negedge clk);
  endtask

  task automatic field_check(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= !out_idle_en || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    frwl_pkg::out_item_t exp_ev;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("tb: failure");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_item);
      end else begin
        exp_ev = expected_events.pop_front();
        field_check("event_kind", exp_ev.event_kind, out_item.event_kind);
        field_check("granted_id", exp_ev.granted_id, out_item.granted_id);
        field_check("granted_write", exp_ev.granted_write, out_item.granted_write);
        field_check("last_of_run", exp_ev.last_of_run, out_item.last_of_run);
      end
    end
  end

  initial begin
    frwl_pkg::in_item_t it;
    int unsigned        acq_pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    pend_head = '0;
    pend_tail = '0;
    pend_cnt = '0;
    readers_held = '0;
    writer_held = 1'b0;
    acq_pct = 50;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[r]) drive_item(directed[r].item, directed[r].fixed, directed[r].fixed_res);

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 50 == 0) acq_pct = $urandom_range(35, 70);
      in_idle_en = !(n >= 150 && n < 250);
      out_idle_en = in_idle_en;
      it.requester_id = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < acq_pct) begin
        it.op = frwl_pkg::OP_ACQUIRE;
        it.is_write = ($urandom_range(0, 99) < 30);
      end else begin
        it.op = frwl_pkg::OP_RELEASE;
        if ($urandom_range(0, 9) == 0) it.is_write = 1'($urandom_range(0, 1));
        else if (writer_held) it.is_write = 1'b1;
        else if (readers_held != 0) it.is_write = 1'b0;
        else it.is_write = 1'($urandom_range(0, 1));
      end
      drive_item(it, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/frwl_pkg.sv
rtl/frwl_ctrl.sv
rtl/frwl_dpath.sv
rtl/fifo_readers_writers_lock.sv
dv/tb_fifo_readers_writers_lock.sv
